>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// LCD sequencer package
// Operation codes, microcode word format and the microprogram table.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   typedef enum logic [3:0] {
      ACT_INIT      = 4'd0,
      ACT_CLEAR     = 4'd1,
      ACT_HOME      = 4'd2,
      ACT_MOVE      = 4'd3,
      ACT_DISPLAY   = 4'd4,
      ACT_CURSOR    = 4'd5,
      ACT_BLINK     = 4'd6,
      ACT_BACKLIGHT = 4'd7,
      ACT_AUTOSCRL  = 4'd8,
      ACT_SCRL_LEFT = 4'd9,
      ACT_SCRL_RGHT = 4'd10,
      ACT_LTR       = 4'd11,
      ACT_RTL       = 4'd12,
      ACT_GLYPH     = 4'd13,
      ACT_CHAR      = 4'd14,
      ACT_NONE      = 4'd15
   } action_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_NIB   = 2'd1,
      KIND_VALUE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      SRC_CONST     = 3'd0,
      SRC_FUNC      = 3'd1,
      SRC_DISP      = 3'd2,
      SRC_ENTRY     = 3'd3,
      SRC_MOVE      = 3'd4,
      SRC_GLYPH_CMD = 3'd5,
      SRC_GLYPH_ROW = 3'd6,
      SRC_CHAR      = 3'd7
   } src_type;

   typedef enum logic [2:0] {
      W_NONE  = 3'd0,
      W_100   = 3'd1,
      W_2000  = 3'd2,
      W_4500  = 3'd3,
      W_50000 = 3'd4
   } wait_type;

   typedef struct packed {
      kind_type   kind;
      src_type    src;
      logic [7:0] konst;
      logic       sel;
      wait_type   xwait;
      logic       repeat_row;
      logic       last;
   } ucode_type;

   localparam int PcWidth = 5;
   typedef logic [PcWidth-1:0] pc_type;

   localparam pc_type PC_INIT      = 5'd0;
   localparam pc_type PC_CLEAR     = 5'd9;
   localparam pc_type PC_HOME      = 5'd10;
   localparam pc_type PC_MOVE      = 5'd11;
   localparam pc_type PC_DISP      = 5'd12;
   localparam pc_type PC_ENTRY     = 5'd13;
   localparam pc_type PC_BACKLIGHT = 5'd14;
   localparam pc_type PC_SCRL_LEFT = 5'd15;
   localparam pc_type PC_SCRL_RGHT = 5'd16;
   localparam pc_type PC_GLYPH     = 5'd17;
   localparam pc_type PC_CHAR      = 5'd19;

   localparam logic [7:0] EnBit   = 8'h04;
   localparam logic [15:0] EnWait = 16'd20;

   function automatic logic [15:0] wait_us(input wait_type w);
      logic [15:0] r;
      case (w)
         W_NONE:  r = 16'd0;
         W_100:   r = 16'd100;
         W_2000:  r = 16'd2000;
         W_4500:  r = 16'd4500;
         W_50000: r = 16'd50000;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] line_base(input logic [1:0] r);
      logic [7:0] b;
      case (r)
         2'd0:    b = 8'h00;
         2'd1:    b = 8'h40;
         2'd2:    b = 8'h14;
         2'd3:    b = 8'h54;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic pc_type entry_pc(input action_type a);
      pc_type p;
      case (a)
         ACT_INIT:                          p = PC_INIT;
         ACT_CLEAR:                         p = PC_CLEAR;
         ACT_HOME:                          p = PC_HOME;
         ACT_MOVE:                          p = PC_MOVE;
         ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: p = PC_DISP;
         ACT_BACKLIGHT:                     p = PC_BACKLIGHT;
         ACT_AUTOSCRL, ACT_LTR, ACT_RTL:    p = PC_ENTRY;
         ACT_SCRL_LEFT:                     p = PC_SCRL_LEFT;
         ACT_SCRL_RGHT:                     p = PC_SCRL_RGHT;
         ACT_GLYPH:                         p = PC_GLYPH;
         ACT_CHAR:                          p = PC_CHAR;
         default:                           p = PC_INIT;
      endcase
      return p;
   endfunction

   // Fields: kind, source, constant, select, extra wait, repeat per glyph row, last.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type u;
      case (pc)
         5'd0:  u = '{KIND_BYTE,  SRC_CONST,     8'h00, 1'b0, W_50000, 1'b0, 1'b0};
         5'd1:  u = '{KIND_NIB,   SRC_CONST,     8'h30, 1'b0, W_4500,  1'b0, 1'b0};
         5'd2:  u = '{KIND_NIB,   SRC_CONST,     8'h30, 1'b0, W_4500,  1'b0, 1'b0};
         5'd3:  u = '{KIND_NIB,   SRC_CONST,     8'h30, 1'b0, W_4500,  1'b0, 1'b0};
         5'd4:  u = '{KIND_NIB,   SRC_CONST,     8'h20, 1'b0, W_100,   1'b0, 1'b0};
         5'd5:  u = '{KIND_VALUE, SRC_FUNC,      8'h00, 1'b0, W_NONE,  1'b0, 1'b0};
         5'd6:  u = '{KIND_VALUE, SRC_DISP,      8'h00, 1'b0, W_NONE,  1'b0, 1'b0};
         5'd7:  u = '{KIND_VALUE, SRC_CONST,     8'h01, 1'b0, W_2000,  1'b0, 1'b0};
         5'd8:  u = '{KIND_VALUE, SRC_ENTRY,     8'h00, 1'b0, W_4500,  1'b0, 1'b1};
         5'd9:  u = '{KIND_VALUE, SRC_CONST,     8'h01, 1'b0, W_2000,  1'b0, 1'b1};
         5'd10: u = '{KIND_VALUE, SRC_CONST,     8'h02, 1'b0, W_2000,  1'b0, 1'b1};
         5'd11: u = '{KIND_VALUE, SRC_MOVE,      8'h00, 1'b0, W_NONE,  1'b0, 1'b1};
         5'd12: u = '{KIND_VALUE, SRC_DISP,      8'h00, 1'b0, W_NONE,  1'b0, 1'b1};
         5'd13: u = '{KIND_VALUE, SRC_ENTRY,     8'h00, 1'b0, W_NONE,  1'b0, 1'b1};
         5'd14: u = '{KIND_BYTE,  SRC_CONST,     8'h00, 1'b0, W_NONE,  1'b0, 1'b1};
         5'd15: u = '{KIND_VALUE, SRC_CONST,     8'h18, 1'b0, W_NONE,  1'b0, 1'b1};
         5'd16: u = '{KIND_VALUE, SRC_CONST,     8'h1C, 1'b0, W_NONE,  1'b0, 1'b1};
         5'd17: u = '{KIND_VALUE, SRC_GLYPH_CMD, 8'h00, 1'b0, W_NONE,  1'b0, 1'b0};
         5'd18: u = '{KIND_VALUE, SRC_GLYPH_ROW, 8'h00, 1'b1, W_NONE,  1'b1, 1'b1};
         5'd19: u = '{KIND_VALUE, SRC_CHAR,      8'h00, 1'b1, W_NONE,  1'b0, 1'b1};
         default: u = '{KIND_BYTE, SRC_CONST,    8'h00, 1'b0, W_NONE,  1'b0, 1'b1};
      endcase
      return u;
   endfunction

endpackage

>>> rtl/char_lcd_nibble_command_sequencer.sv
// ----------------------------------------------------------------------------
// Character LCD nibble command sequencer
// Turns LCD operations into the port-expander bytes of a 4-bit display bus.
// ----------------------------------------------------------------------------
// One operation is taken per request transfer and answered with a run of
// response transfers, one expander byte each, the final one flagged by
// rsp_last. A microprogram step counter walks a small table; each step emits
// one byte, one nibble (three bytes) or one full command or data byte (six
// bytes), one byte per cycle while the response side keeps up. A new request
// is taken once the last byte of the previous one sits in the output
// register; the ACT_NONE operation code is taken and produces nothing.
module char_lcd_nibble_command_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [1:0]  req_row,
   input  logic [5:0]  req_column,
   input  logic        req_enable_flag,
   input  logic [2:0]  req_glyph_slot,
   input  logic [63:0] req_glyph_rows,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_expander_byte,
   output logic [15:0] rsp_wait_after_us,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_row_count
);
   import lcdseq_pkg::*;

   logic [2:0]  row_count_ff, row_count_in;
   logic [2:0]  disp_ff, disp_in;
   logic [1:0]  entry_ff, entry_in;
   logic        bl_ff, bl_in;
   logic        busy_ff, busy_in;
   pc_type      pc_ff, pc_in;
   logic [2:0]  sub_ff, sub_in;
   logic [2:0]  gidx_ff, gidx_in;

   logic [1:0]  row_ff, row_in;
   logic [5:0]  col_ff, col_in;
   logic [2:0]  slot_ff, slot_in;
   logic [63:0] glyph_ff, glyph_in;
   logic [7:0]  char_ff, char_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] wait_ff, wait_in;
   logic        last_ff, last_in;

   ucode_type   uc;
   action_type  act;
   logic        accept, advance, step_done, repeat_now;
   logic [7:0]  value, nib, out_byte, bl_mask;
   logic [1:0]  phase;
   logic [1:0]  move_row;
   logic [2:0]  disp_mask;
   logic [15:0] out_wait;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 3'd2;
         disp_ff      <= '0;
         entry_ff     <= '0;
         bl_ff        <= 1'b0;
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         sub_ff       <= '0;
         gidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         disp_ff      <= disp_in;
         entry_ff     <= entry_in;
         bl_ff        <= bl_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         sub_ff       <= sub_in;
         gidx_ff      <= gidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      slot_ff  <= slot_in;
      glyph_ff <= glyph_in;
      char_ff  <= char_in;
      byte_ff  <= byte_in;
      wait_ff  <= wait_in;
      last_ff  <= last_in;
   end

   assign req_ready         = ~busy_ff;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expander_byte = byte_ff;
   assign rsp_wait_after_us = wait_ff;
   assign rsp_last          = last_ff;

   assign act     = action_type'(req_action);
   assign accept  = req_valid & ~busy_ff;
   assign advance = busy_ff & (~rsp_valid_ff | rsp_ready);
   assign uc      = ucode_rom(pc_ff);
   assign bl_mask = {4'b0000, bl_ff, 3'b000};

   always_comb begin
      case (act)
         ACT_DISPLAY: disp_mask = 3'b100;
         ACT_CURSOR:  disp_mask = 3'b010;
         ACT_BLINK:   disp_mask = 3'b001;
         default:     disp_mask = 3'b000;
      endcase

      if ({1'b0, row_ff} >= row_count_ff) begin
         move_row = (row_count_ff == 3'd0) ? 2'd0 : 2'(row_count_ff - 3'd1);
      end else begin
         move_row = row_ff;
      end

      case (uc.src)
         SRC_CONST:     value = uc.konst;
         SRC_FUNC:      value = (row_count_ff > 3'd1) ? 8'h28 : 8'h24;
         SRC_DISP:      value = {5'b00001, disp_ff};
         SRC_ENTRY:     value = {6'b000001, entry_ff};
         SRC_MOVE:      value = 8'h80 | ({2'b00, col_ff} + line_base(move_row));
         SRC_GLYPH_CMD: value = {2'b01, slot_ff, 3'b000};
         SRC_GLYPH_ROW: value = glyph_ff[{gidx_ff, 3'b000} +: 8];
         SRC_CHAR:      value = char_ff;
         default:       value = uc.konst;
      endcase

      case (uc.kind)
         KIND_BYTE: begin
            step_done = 1'b1;
            phase     = 2'd0;
            nib       = 8'h00;
         end
         KIND_NIB: begin
            step_done = (sub_ff == 3'd2);
            phase     = sub_ff[1:0];
            nib       = uc.konst;
         end
         default: begin
            step_done = (sub_ff == 3'd5);
            if (sub_ff >= 3'd3) begin
               phase = 2'(sub_ff - 3'd3);
               nib   = {value[3:0], 3'b000, uc.sel};
            end else begin
               phase = sub_ff[1:0];
               nib   = {value[7:4], 3'b000, uc.sel};
            end
         end
      endcase

      if (uc.kind == KIND_BYTE) begin
         out_byte = bl_mask;
         out_wait = wait_us(uc.xwait);
      end else begin
         case (phase)
            2'd0:    out_byte = nib | bl_mask;
            2'd1:    out_byte = nib | EnBit | bl_mask;
            default: out_byte = (nib & ~EnBit) | bl_mask;
         endcase
         if (phase == 2'd0) begin
            out_wait = 16'd0;
         end else if (step_done) begin
            out_wait = EnWait + wait_us(uc.xwait);
         end else begin
            out_wait = EnWait;
         end
      end

      repeat_now = uc.repeat_row & (gidx_ff != 3'd7);

      row_count_in = (csr_valid) ? csr_row_count : row_count_ff;
      disp_in      = disp_ff;
      entry_in     = entry_ff;
      bl_in        = bl_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      sub_in       = sub_ff;
      gidx_in      = gidx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      glyph_in     = glyph_ff;
      char_in      = char_ff;
      byte_in      = byte_ff;
      wait_in      = wait_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (accept) begin
         row_in   = req_row;
         col_in   = req_column;
         slot_in  = req_glyph_slot;
         glyph_in = req_glyph_rows;
         char_in  = req_char_code;
         pc_in    = entry_pc(act);
         sub_in   = '0;
         gidx_in  = '0;
         busy_in  = (act != ACT_NONE);
         case (act)
            ACT_INIT: begin
               bl_in    = 1'b1;
               disp_in  = 3'b100;
               entry_in = 2'b10;
            end
            ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: begin
               disp_in = req_enable_flag ? (disp_ff | disp_mask) : (disp_ff & ~disp_mask);
            end
            ACT_BACKLIGHT: bl_in       = req_enable_flag;
            ACT_AUTOSCRL:  entry_in[0] = req_enable_flag;
            ACT_LTR:       entry_in[1] = 1'b1;
            ACT_RTL:       entry_in[1] = 1'b0;
            default: begin
            end
         endcase
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         byte_in      = out_byte;
         wait_in      = out_wait;
         last_in      = step_done & uc.last & ~repeat_now;
         if (!step_done) begin
            sub_in = sub_ff + 3'd1;
         end else begin
            sub_in = '0;
            if (repeat_now) begin
               gidx_in = gidx_ff + 3'd1;
            end else if (uc.last) begin
               busy_in = 1'b0;
            end else begin
               pc_in = pc_ff + 5'd1;
            end
         end
      end
   end

endmodule

>>> rtl/lcdseq_checker.sv
// ----------------------------------------------------------------------------
// LCD sequencer checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdseq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [3:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_expander_byte,
   input logic [15:0] rsp_wait_after_us,
   input logic        rsp_last
);
   import lcdseq_pkg::*;

   logic req_xfer, rsp_stall, none_xfer, cmd_xfer;

   assign req_xfer  = req_valid & req_ready;
   assign rsp_stall = rsp_valid & ~rsp_ready;
   assign none_xfer = req_xfer & (req_action == ACT_NONE);
   assign cmd_xfer  = req_xfer & (req_action != ACT_NONE);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_expander_byte) && $stable(rsp_wait_after_us) && $stable(rsp_last))
   `ASSERT_IMPLY(a_no_req_mid_run, clock, reset, rsp_valid && !rsp_last, !req_ready)
   `ASSERT_NEXT(a_cmd_busy, clock, reset, cmd_xfer, !req_ready)
   `ASSERT_NEXT(a_none_idle, clock, reset, none_xfer, req_ready)
   `ASSERT_IMPLY(a_bit1_clear, clock, reset, rsp_valid, !rsp_expander_byte[1])

endmodule

bind char_lcd_nibble_command_sequencer lcdseq_checker u_lcdseq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_expander_byte (rsp_expander_byte),
   .rsp_wait_after_us (rsp_wait_after_us),
   .rsp_last          (rsp_last)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble command sequencer testbench
// A queue of LCD operations, directed first and then random, is fed to the
// sequencer through a driver with random idle bursts. A monitor with its own
// random stalls checks every expander byte, its wait and its last flag
// against a predictor that tracks the display, entry-mode and backlight state
// and the row count written through the register port between phases.
// ----------------------------------------------------------------------------
module testbench;
   import lcdseq_pkg::*;

   localparam int ClockHalf      = 5;
   localparam int ResetCycles    = 5;
   localparam int DrainCycles    = 64;
   localparam int WatchdogLimit  = 5000;
   localparam int HoldOffStart   = 30;
   localparam int HoldOffCycles  = 400;
   localparam int PhaseCount     = 7;
   localparam int RandomPerPhase = 18;
   localparam int PrintLimit     = 50;

   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] CMD_ENTRY       = 8'h04;
   localparam logic [7:0] CMD_DISPLAY     = 8'h08;
   localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
   localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
   localparam logic [7:0] CMD_FUNCTION    = 8'h20;
   localparam logic [7:0] CMD_CGRAM       = 8'h40;
   localparam logic [7:0] CMD_DDRAM       = 8'h80;
   localparam logic [7:0] WAKE_NIBBLE     = 8'h30;
   localparam logic [7:0] MODE_NIBBLE     = 8'h20;
   localparam logic [7:0] TWO_LINE_MODE   = 8'h08;
   localparam logic [7:0] TALL_FONT_MODE  = 8'h04;

   localparam logic [7:0] BACKLIGHT_MASK = 8'h08;
   localparam logic [7:0] ENABLE_MASK    = 8'h04;
   localparam logic [7:0] SELECT_MASK    = 8'h01;
   localparam logic [7:0] NO_SELECT      = 8'h00;

   localparam logic [2:0] DISPLAY_ON_MASK = 3'h4;
   localparam logic [2:0] CURSOR_ON_MASK  = 3'h2;
   localparam logic [2:0] BLINK_ON_MASK   = 3'h1;

   localparam logic [3:0][7:0] ROW_OFFSET = {8'h54, 8'h14, 8'h40, 8'h00};
   localparam logic [PhaseCount-1:0][2:0] ROW_SETTINGS =
      {3'd0, 3'd3, 3'd7, 3'd0, 3'd4, 3'd1, 3'd2};

   typedef struct packed {
      action_type  action;
      logic [1:0]  row;
      logic [5:0]  column;
      logic        enable_flag;
      logic [2:0]  glyph_slot;
      logic [63:0] glyph_rows;
      logic [7:0]  char_code;
   } lcd_op_type;

   typedef struct packed {
      logic [7:0]  expander_byte;
      logic [15:0] wait_after_us;
      logic        last;
   } expander_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_action = '0;
   logic [1:0]  req_row = '0;
   logic [5:0]  req_column = '0;
   logic        req_enable_flag = 1'b0;
   logic [2:0]  req_glyph_slot = '0;
   logic [63:0] req_glyph_rows = '0;
   logic [7:0]  req_char_code = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_expander_byte;
   logic [15:0] rsp_wait_after_us;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_row_count = '0;

   logic [2:0] lcd_rows = 3'd2;
   logic [2:0] display_bits = '0;
   logic [1:0] entry_bits = '0;
   logic       backlight_on = 1'b0;

   lcd_op_type         pending_ops[$];
   lcd_op_type         offered_op;
   expander_write_type op_writes[$];
   expander_write_type expected_writes[$];

   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int unsigned send_idle_pct = 30;
   int unsigned recv_idle_pct = 30;
   logic        quiet_tail = 1'b0;
   int unsigned accepted_reqs = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   char_lcd_nibble_command_sequencer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_row           (req_row),
      .req_column        (req_column),
      .req_enable_flag   (req_enable_flag),
      .req_glyph_slot    (req_glyph_slot),
      .req_glyph_rows    (req_glyph_rows),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_expander_byte (rsp_expander_byte),
      .rsp_wait_after_us (rsp_wait_after_us),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_row_count     (csr_row_count)
   );

   always #ClockHalf clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatches < PrintLimit) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
      mismatches++;
   endtask

   function automatic void push_write(input logic [7:0] value, input logic [15:0] wait_us);
      expander_write_type w;
      w.expander_byte = value | (backlight_on ? BACKLIGHT_MASK : 8'h00);
      w.wait_after_us = wait_us;
      w.last = 1'b0;
      op_writes.push_back(w);
   endfunction

   function automatic void extend_wait(input logic [15:0] extra);
      expander_write_type w;
      if (op_writes.size() > 0) begin
         w = op_writes.pop_back();
         w.wait_after_us = w.wait_after_us + extra;
         op_writes.push_back(w);
      end
   endfunction

   function automatic void push_nibble(input logic [7:0] value);
      push_write(value, 16'd0);
      push_write(value | ENABLE_MASK, 16'd20);
      push_write(value & ~ENABLE_MASK, 16'd20);
   endfunction

   function automatic void push_lcd_byte(input logic [7:0] value, input logic [7:0] sel);
      push_nibble({value[7:4], 4'h0} | sel);
      push_nibble({value[3:0], 4'h0} | sel);
   endfunction

   function automatic void predict_expander_writes(input lcd_op_type op);
      logic [2:0]         mask;
      logic [7:0]         address;
      int                 line;
      int                 i;
      expander_write_type w;
      op_writes.delete();
      case (op.action)
         ACT_INIT: begin
            backlight_on = 1'b1;
            push_write(8'h00, 16'd50000);
            for (i = 0; i < 3; i++) begin
               push_nibble(WAKE_NIBBLE);
               extend_wait(16'd4500);
            end
            push_nibble(MODE_NIBBLE);
            extend_wait(16'd100);
            push_lcd_byte(CMD_FUNCTION | ((lcd_rows > 3'd1) ? TWO_LINE_MODE : TALL_FONT_MODE),
                          NO_SELECT);
            display_bits = DISPLAY_ON_MASK;
            push_lcd_byte(CMD_DISPLAY | display_bits, NO_SELECT);
            push_lcd_byte(CMD_CLEAR, NO_SELECT);
            extend_wait(16'd2000);
            entry_bits = 2'b10;
            push_lcd_byte(CMD_ENTRY | entry_bits, NO_SELECT);
            extend_wait(16'd4500);
         end
         ACT_CLEAR: begin
            push_lcd_byte(CMD_CLEAR, NO_SELECT);
            extend_wait(16'd2000);
         end
         ACT_HOME: begin
            push_lcd_byte(CMD_HOME, NO_SELECT);
            extend_wait(16'd2000);
         end
         ACT_MOVE: begin
            line = op.row;
            if (line >= lcd_rows) begin
               line = (lcd_rows == 3'd0) ? 0 : lcd_rows - 1;
            end
            address = {2'b00, op.column} + ROW_OFFSET[line[1:0]];
            push_lcd_byte(CMD_DDRAM | address, NO_SELECT);
         end
         ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: begin
            mask = (op.action == ACT_DISPLAY) ? DISPLAY_ON_MASK :
                   (op.action == ACT_CURSOR) ? CURSOR_ON_MASK : BLINK_ON_MASK;
            display_bits = op.enable_flag ? (display_bits | mask) : (display_bits & ~mask);
            push_lcd_byte(CMD_DISPLAY | display_bits, NO_SELECT);
         end
         ACT_BACKLIGHT: begin
            backlight_on = op.enable_flag;
            push_write(8'h00, 16'd0);
         end
         ACT_AUTOSCRL: begin
            entry_bits[0] = op.enable_flag;
            push_lcd_byte(CMD_ENTRY | entry_bits, NO_SELECT);
         end
         ACT_SCRL_LEFT: push_lcd_byte(CMD_SHIFT_LEFT, NO_SELECT);
         ACT_SCRL_RGHT: push_lcd_byte(CMD_SHIFT_RIGHT, NO_SELECT);
         ACT_LTR: begin
            entry_bits[1] = 1'b1;
            push_lcd_byte(CMD_ENTRY | entry_bits, NO_SELECT);
         end
         ACT_RTL: begin
            entry_bits[1] = 1'b0;
            push_lcd_byte(CMD_ENTRY | entry_bits, NO_SELECT);
         end
         ACT_GLYPH: begin
            push_lcd_byte(CMD_CGRAM | {2'b00, op.glyph_slot, 3'b000}, NO_SELECT);
            for (i = 0; i < 8; i++) begin
               push_lcd_byte(op.glyph_rows[8*i +: 8], SELECT_MASK);
            end
         end
         ACT_CHAR: push_lcd_byte(op.char_code, SELECT_MASK);
         default: ;
      endcase
      if (op_writes.size() > 0) begin
         w = op_writes.pop_back();
         w.last = 1'b1;
         op_writes.push_back(w);
      end
      while (op_writes.size() > 0) begin
         expected_writes.push_back(op_writes.pop_front());
      end
   endfunction

   function automatic lcd_op_type random_op();
      lcd_op_type  op;
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
         op.action = ACT_INIT;
      end else if (pick < 12) begin
         op.action = ACT_GLYPH;
      end else if (pick < 15) begin
         op.action = ACT_NONE;
      end else begin
         op.action = action_type'($urandom_range(14, 1));
      end
      op.row = 2'($urandom);
      op.column = 6'($urandom);
      op.enable_flag = 1'($urandom);
      op.glyph_slot = 3'($urandom);
      op.glyph_rows = {$urandom, $urandom};
      op.char_code = 8'($urandom);
      return op;
   endfunction

   task automatic add_op(input action_type action, input logic [1:0] row,
                         input logic [5:0] column, input logic flag,
                         input logic [2:0] slot, input logic [63:0] glyph,
                         input logic [7:0] code);
      lcd_op_type op;
      op.action = action;
      op.row = row;
      op.column = column;
      op.enable_flag = flag;
      op.glyph_slot = slot;
      op.glyph_rows = glyph;
      op.char_code = code;
      pending_ops.push_back(op);
   endtask

   // A move is often followed by a short string of characters.
   task automatic add_random_op();
      lcd_op_type op;
      int         n;
      int         k;
      op = random_op();
      pending_ops.push_back(op);
      if (op.action == ACT_MOVE && $urandom_range(1, 0) == 1) begin
         n = $urandom_range(8, 2);
         for (k = 0; k < n; k++) begin
            op = random_op();
            op.action = ACT_CHAR;
            pending_ops.push_back(op);
         end
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_ops.size() != 0 || req_valid || expected_writes.size() != 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_row_count(input logic [2:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_row_count <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      lcd_rows = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         display_bits = '0;
         entry_bits = '0;
         backlight_on = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_expander_writes(offered_op);
            accepted_reqs <= accepted_reqs + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0 && !quiet_tail &&
                         $urandom_range(99, 0) < send_idle_pct) begin
               send_gap = $urandom_range(15, 0);
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               offered_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_action <= offered_op.action;
               req_row <= offered_op.row;
               req_column <= offered_op.column;
               req_enable_flag <= offered_op.enable_flag;
               req_glyph_slot <= offered_op.glyph_slot;
               req_glyph_rows <= offered_op.glyph_rows;
               req_char_code <= offered_op.char_code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off lets the sequencer fill up and stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_reqs >= HoldOffStart) begin
         hold_done = 1'b1;
         hold_left = HoldOffCycles - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(99, 0) < recv_idle_pct) begin
         stall_left = $urandom_range(15, 0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      expander_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, byte %02h", rsp_expander_byte));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_expander_byte !== want.expander_byte) begin
               report_mismatch($sformatf("expander_byte %02h, expected %02h",
                                         rsp_expander_byte, want.expander_byte));
            end
            if (rsp_wait_after_us !== want.wait_after_us) begin
               report_mismatch($sformatf("wait_after_us %0d, expected %0d",
                                         rsp_wait_after_us, want.wait_after_us));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
         $display("[char_lcd_nibble_command_sequencer] ERROR");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin : stimulus
      int         phase;
      int         k;
      logic [2:0] setting;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PhaseCount; phase++) begin
         if (phase > 0) begin
            wait_idle();
            setting = (phase == PhaseCount - 1) ? 3'($urandom_range(7, 0)) : ROW_SETTINGS[phase];
            write_row_count(setting);
         end
         @(negedge clock);
         quiet_tail = (phase == PhaseCount - 1);
         send_idle_pct = (phase == 1) ? 0 : $urandom_range(60, 5);
         recv_idle_pct = (phase == 1) ? 0 : $urandom_range(60, 5);
         if (phase == 0) begin
            add_op(ACT_NONE, 2'd3, 6'd63, 1'b1, 3'd7, '1, 8'hFF);
            add_op(ACT_INIT, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_CLEAR, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_HOME, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_MOVE, 2'd3, 6'd63, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_MOVE, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_MOVE, 2'd1, 6'd39, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_DISPLAY, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_DISPLAY, 2'd0, 6'd0, 1'b1, 3'd0, '0, 8'h00);
            add_op(ACT_CURSOR, 2'd0, 6'd0, 1'b1, 3'd0, '0, 8'h00);
            add_op(ACT_BLINK, 2'd0, 6'd0, 1'b1, 3'd0, '0, 8'h00);
            add_op(ACT_CURSOR, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_BACKLIGHT, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_CHAR, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'hFF);
            add_op(ACT_BACKLIGHT, 2'd0, 6'd0, 1'b1, 3'd0, '0, 8'h00);
            add_op(ACT_AUTOSCRL, 2'd0, 6'd0, 1'b1, 3'd0, '0, 8'h00);
            add_op(ACT_AUTOSCRL, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_SCRL_LEFT, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_SCRL_RGHT, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_RTL, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_LTR, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_GLYPH, 2'd0, 6'd0, 1'b0, 3'd7, '1, 8'h00);
            add_op(ACT_GLYPH, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            add_op(ACT_CHAR, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
         end else begin
            add_op(ACT_INIT, 2'd0, 6'd0, 1'b0, 3'd0, '0, 8'h00);
            for (k = 0; k < 4; k++) begin
               add_op(ACT_MOVE, 2'(k), 6'($urandom), 1'b0, 3'd0, '0, 8'h00);
            end
            add_op(ACT_MOVE, 2'd3, 6'd63, 1'b0, 3'd0, '0, 8'h00);
         end
         for (k = 0; k < RandomPerPhase; k++) begin
            add_random_op();
         end
      end
      wait_idle();
      if (expected_writes.size() != 0) begin
         report_mismatch($sformatf("%0d expected transfers never arrived",
                                   expected_writes.size()));
      end
      if (mismatches == 0) begin
         $display("[char_lcd_nibble_command_sequencer] OK");
      end else begin
         $display("[char_lcd_nibble_command_sequencer] ERROR");
      end
      $finish;
   end

endmodule
